### rtl/gres_pkg.sv
// Shared types and constants for the graph reachability edge store.
package gres_pkg;

    // Field widths fixed by the request and response formats
    localparam int VID_W  = 6;
    localparam int VCNT_W = 7;
    localparam int CNT_W  = 13;
    localparam int VMAX   = 64;

    // Request operation codes
    typedef enum logic [2:0] {
        FN_ADD       = 3'd0,
        FN_REMOVE    = 3'd1,
        FN_HAS       = 3'd2,
        FN_REACH     = 3'd3,
        FN_REACH_CUT = 3'd4,
        FN_REDUNDANT = 3'd5
    } func_t;

    typedef struct packed {
        logic [2:0]       func;
        logic [VID_W-1:0] src_vertex;
        logic [VID_W-1:0] dst_vertex;
        logic [VID_W-1:0] skip_from;
        logic [VID_W-1:0] skip_to;
    } gres_req_t;

    typedef struct packed {
        logic             ok;
        logic [CNT_W-1:0] edges_now;
    } gres_rsp_t;

    // Commands from the controller to the search unit
    typedef struct packed {
        logic load;
        logic run;
        logic use_cut;
    } gres_srch_cmd_t;

    // Status from the search unit
    typedef struct packed {
        logic found;
        logic exhausted;
    } gres_srch_sts_t;

endpackage

### rtl/gres_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module gres_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/gres_search.sv
// Frontier search unit: visited/pending masks, row pick and row expansion.
module gres_search
    import gres_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  gres_srch_cmd_t           cmd,
    input  logic [VID_W-1:0]         start_vertex,
    input  logic [VID_W-1:0]         goal_vertex,
    input  logic [VID_W-1:0]         cut_from,
    input  logic [VID_W-1:0]         cut_to,
    input  logic [DEPTH-1:0]         valid_mask,
    input  logic [DEPTH-1:0]         row,
    output logic                     rd_en,
    output logic [$clog2(DEPTH)-1:0] rd_addr,
    output gres_srch_sts_t           sts
);

    localparam int AW = $clog2(DEPTH);

    logic [DEPTH-1:0] visited_reg, visited_next;
    logic [DEPTH-1:0] pending_reg, pending_next;
    logic             flight_reg, flight_next;
    logic [AW-1:0]    cur_reg, cur_next;

    logic [DEPTH-1:0] pick_oh;
    logic             pick_valid;
    logic [AW-1:0]    pick_idx;
    logic [DEPTH-1:0] row_m;
    logic [DEPTH-1:0] fresh;

    // Lowest pending vertex is expanded next
    assign pick_oh    = pending_reg & (~pending_reg + DEPTH'(1));
    assign pick_valid = |pending_reg;

    always_comb begin
        pick_idx = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (pick_oh[i]) begin
                pick_idx = pick_idx | AW'(i);
            end
        end
    end

    // Row in flight: drop invalid targets and the excluded edge
    always_comb begin
        row_m = row & valid_mask;
        if (cmd.use_cut && (cut_from == VID_W'(cur_reg))) begin
            row_m = row_m & ~(DEPTH'(1) << cut_to[AW-1:0]);
        end
    end

    assign fresh         = row_m & ~visited_reg;
    assign sts.found     = flight_reg && row_m[goal_vertex[AW-1:0]];
    assign sts.exhausted = !flight_reg && !pick_valid;
    assign rd_en         = cmd.run && pick_valid;
    assign rd_addr       = pick_idx;

    // Mask update
    always_comb begin
        visited_next = visited_reg;
        pending_next = pending_reg;
        flight_next  = flight_reg;
        cur_next     = cur_reg;
        if (cmd.load) begin
            visited_next = DEPTH'(1) << start_vertex[AW-1:0];
            pending_next = '0;
            flight_next  = 1'b1;
            cur_next     = start_vertex[AW-1:0];
        end else if (cmd.run) begin
            pending_next = pending_reg & ~pick_oh;
            if (flight_reg) begin
                visited_next = visited_reg | fresh;
                pending_next = pending_next | fresh;
            end
            flight_next = pick_valid;
            if (pick_valid) begin
                cur_next = pick_idx;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            visited_reg <= '0;
            pending_reg <= '0;
            flight_reg  <= 1'b0;
        end else begin
            visited_reg <= visited_next;
            pending_reg <= pending_next;
            flight_reg  <= flight_next;
        end
        cur_reg <= cur_next;
    end

`ifndef SYNTHESIS
    // Every pending vertex has already been marked visited
    a_pending_in_visited: assert property (@(posedge aclk) disable iff (!aresetn)
        (pending_reg & ~visited_reg) == '0)
        else $error("pending vertex not in visited set");

    // A load always puts the start row in flight
    a_load_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> flight_reg)
        else $error("start row not in flight after load");
`endif

endmodule

### rtl/graph_reachability_edge_store.sv
// Top level: request control, edge counter and adjacency row storage.
//
// Usage: requests enter on s_valid/s_ready with s_req; one response per
// request leaves on m_valid/m_ready with m_rsp (ok flag, edge count).
// cfg_valid/cfg_ready/cfg_data writes vertex_count; cfg_ready is always
// high and writes are expected only while no request is in progress.
// Add, remove and has-edge requests: the source row read is registered
// with the request, S_ROW decodes and writes the row, and S_DONE loads
// the output register once it is free.
// Reachability, skip-edge and redundancy requests: the search expands
// one adjacency row per read of the row RAM; the single read port of
// the row RAM bounds how fast rows are expanded.
// A new request is taken once the previous one has moved into the output
// register, so one response may wait on a stalled receiver while the
// next request is in progress; a further response holds in the
// controller until the output register frees.
// Reset (aresetn low, synchronous) clears the edge count, vertex_count,
// the row-valid bits (all rows read as empty) and the output valid flag.
module graph_reachability_edge_store
    import gres_pkg::*;
#(
    parameter int MAX_VERTICES = 64
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  gres_req_t         s_req,
    output logic              m_valid,
    input  logic              m_ready,
    output gres_rsp_t         m_rsp,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [VCNT_W-1:0] cfg_data
);

    localparam int DEPTH = (MAX_VERTICES < VMAX) ? MAX_VERTICES : VMAX;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [VCNT_W-1:0] DEPTH_C  = VCNT_W'(DEPTH);
    localparam logic [CNT_W-1:0]  EDGE_MAX = CNT_W'(DEPTH * DEPTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_ROW,
        S_SEARCH,
        S_DONE
    } state_t;

    state_t           state_reg, state_next;
    gres_req_t        req_reg, req_next;
    logic             both_reg, both_next;
    logic             skipok_reg, skipok_next;
    logic             ok_reg, ok_next;
    logic [CNT_W-1:0] edge_total_reg, edge_total_next;
    logic [VCNT_W-1:0] vcount_reg;
    logic             m_valid_reg, m_valid_next;
    gres_rsp_t        m_rsp_reg, m_rsp_next;
    logic [DEPTH-1:0] rvalid_reg;
    logic             rvq_reg;

    logic [VCNT_W-1:0] active;
    logic [DEPTH-1:0]  valid_mask;
    logic              src_ok, dst_ok, kfrom_ok, kto_ok;

    logic              ram_we, ram_re;
    logic [AW-1:0]     ram_raddr;
    logic [DEPTH-1:0]  ram_wdata, ram_rdata, row;
    logic [AW-1:0]     src_idx, dst_idx;
    logic [DEPTH-1:0]  dst_oh;
    logic              edge_bit, same_vertex;

    gres_srch_cmd_t    srch_cmd;
    gres_srch_sts_t    srch_sts;
    logic              srch_rd_en;
    logic [AW-1:0]     srch_rd_addr;
    logic [VID_W-1:0]  cut_from, cut_to;

    // Vertices in use, clamped to the storage size
    assign active = (vcount_reg > DEPTH_C) ? DEPTH_C : vcount_reg;

    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            valid_mask[i] = (VCNT_W'(i) < active);
        end
    end

    assign src_ok   = {1'b0, s_req.src_vertex} < active;
    assign dst_ok   = {1'b0, s_req.dst_vertex} < active;
    assign kfrom_ok = {1'b0, s_req.skip_from} < active;
    assign kto_ok   = {1'b0, s_req.skip_to} < active;

    // Row of the current request; rows never written read as empty
    assign row         = ram_rdata & {DEPTH{rvq_reg}};
    assign src_idx     = req_reg.src_vertex[AW-1:0];
    assign dst_idx     = req_reg.dst_vertex[AW-1:0];
    assign dst_oh      = DEPTH'(1) << dst_idx;
    assign edge_bit    = row[dst_idx];
    assign same_vertex = req_reg.src_vertex == req_reg.dst_vertex;

    // Excluded edge: the request's skip edge, or the tested edge itself
    assign cut_from = (func_t'(req_reg.func) == FN_REDUNDANT) ? req_reg.src_vertex
                                                              : req_reg.skip_from;
    assign cut_to   = (func_t'(req_reg.func) == FN_REDUNDANT) ? req_reg.dst_vertex
                                                              : req_reg.skip_to;

    assign s_ready   = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_rsp     = m_rsp_reg;

    // Row RAM read port: request source row first, then search picks
    assign ram_re    = (state_reg == S_IDLE) ? s_valid : srch_rd_en;
    assign ram_raddr = (state_reg == S_IDLE) ? s_req.src_vertex[AW-1:0] : srch_rd_addr;

    // Request control
    always_comb begin
        state_next      = state_reg;
        req_next        = req_reg;
        both_next       = both_reg;
        skipok_next     = skipok_reg;
        ok_next         = ok_reg;
        edge_total_next = edge_total_reg;
        m_valid_next    = m_valid_reg;
        m_rsp_next      = m_rsp_reg;
        ram_we          = 1'b0;
        ram_wdata       = row;
        srch_cmd        = '0;
        srch_cmd.use_cut = (func_t'(req_reg.func) == FN_REACH_CUT) ||
                           (func_t'(req_reg.func) == FN_REDUNDANT);

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    req_next      = s_req;
                    both_next     = src_ok && dst_ok;
                    skipok_next   = kfrom_ok && kto_ok;
                    srch_cmd.load = 1'b1;
                    state_next    = S_ROW;
                end
            end
            S_ROW: begin
                state_next = S_DONE;
                ok_next    = 1'b0;
                case (func_t'(req_reg.func))
                    FN_ADD: begin
                        if (both_reg && !edge_bit) begin
                            ram_we          = 1'b1;
                            ram_wdata       = row | dst_oh;
                            edge_total_next = edge_total_reg + CNT_W'(1);
                            ok_next         = 1'b1;
                        end
                    end
                    FN_REMOVE: begin
                        if (both_reg && edge_bit) begin
                            ram_we          = 1'b1;
                            ram_wdata       = row & ~dst_oh;
                            edge_total_next = edge_total_reg - CNT_W'(1);
                            ok_next         = 1'b1;
                        end
                    end
                    FN_HAS: begin
                        ok_next = both_reg && edge_bit;
                    end
                    FN_REACH, FN_REACH_CUT, FN_REDUNDANT: begin
                        if (!both_reg) begin
                            ok_next = 1'b0;
                        end else if ((func_t'(req_reg.func) == FN_REACH_CUT) && !skipok_reg) begin
                            ok_next = 1'b0;
                        end else if ((func_t'(req_reg.func) == FN_REDUNDANT) && !edge_bit) begin
                            ok_next = 1'b0;
                        end else if (same_vertex) begin
                            ok_next = 1'b1;
                        end else begin
                            // Source row is the first expanded row
                            srch_cmd.run = 1'b1;
                            if (srch_sts.found) begin
                                ok_next = 1'b1;
                            end else begin
                                state_next = S_SEARCH;
                            end
                        end
                    end
                    default: begin
                        ok_next = 1'b0;
                    end
                endcase
            end
            S_SEARCH: begin
                srch_cmd.run = 1'b1;
                if (srch_sts.found) begin
                    ok_next    = 1'b1;
                    state_next = S_DONE;
                end else if (srch_sts.exhausted) begin
                    ok_next    = 1'b0;
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next         = 1'b1;
                    m_rsp_next.ok        = ok_reg;
                    m_rsp_next.edges_now = edge_total_reg;
                    state_next           = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State, counters and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            edge_total_reg <= '0;
            vcount_reg     <= '0;
            m_valid_reg    <= 1'b0;
            rvalid_reg     <= '0;
        end else begin
            state_reg      <= state_next;
            edge_total_reg <= edge_total_next;
            m_valid_reg    <= m_valid_next;
            if (cfg_valid) begin
                vcount_reg <= cfg_data;
            end
            if (ram_we) begin
                rvalid_reg[src_idx] <= 1'b1;
            end
        end
        req_reg    <= req_next;
        both_reg   <= both_next;
        skipok_reg <= skipok_next;
        ok_reg     <= ok_next;
        m_rsp_reg  <= m_rsp_next;
        if (ram_re) begin
            rvq_reg <= rvalid_reg[ram_raddr];
        end
    end

    gres_ram #(
        .WIDTH (DEPTH),
        .DEPTH (DEPTH)
    ) u_rows (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (src_idx),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    gres_search #(
        .DEPTH (DEPTH)
    ) u_search (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (srch_cmd),
        .start_vertex (s_req.src_vertex),
        .goal_vertex  (req_reg.dst_vertex),
        .cut_from     (cut_from),
        .cut_to       (cut_to),
        .valid_mask   (valid_mask),
        .row          (row),
        .rd_en        (srch_rd_en),
        .rd_addr      (srch_rd_addr),
        .sts          (srch_sts)
    );

`ifndef SYNTHESIS
    // Edge count never exceeds the matrix size
    a_edge_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        edge_total_reg <= EDGE_MAX)
        else $error("edge count above matrix size");

    // Every row write comes with a change of the edge count
    a_write_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |=> edge_total_reg != $past(edge_total_reg))
        else $error("row written without edge count change");

    // One request at a time: no new request right after one is taken
    a_one_request: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("request taken while another is in progress");
`endif

endmodule
